@@ src/masked_motion_vector_gridder_assert.svh @@
// Assertion helpers used by the controller RTL.
`ifndef MASKED_MOTION_VECTOR_GRIDDER_ASSERT_SVH
`define MASKED_MOTION_VECTOR_GRIDDER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MMVG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MMVG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mmvg_pkg.sv @@
package mmvg_pkg;

  localparam int NUM_POLY_REGS = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 28;
  localparam int SHIFT_W       = 3;
  localparam int DIM_W         = 11;
  localparam int DIM_MAX       = 1024;
  localparam int THR_W         = 28;
  localparam int POLY_CNT_W    = 5;
  localparam int CELL_W        = 10;
  localparam int VEC_W         = 15;
  localparam int SQ_W          = 27;
  localparam int PX_W          = 18;

  localparam logic [SHIFT_W-1:0] RST_GRID_SHIFT = 3'd4;
  localparam logic [DIM_W-1:0]   RST_GRID_COLS  = 11'd120;
  localparam logic [DIM_W-1:0]   RST_GRID_ROWS  = 11'd68;
  localparam logic [THR_W-1:0]   RST_MAG_THR    = 28'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SHIFT = 3'd0,
    CFG_GRID_COLS  = 3'd1,
    CFG_GRID_ROWS  = 3'd2,
    CFG_MAG_THR    = 3'd3,
    CFG_POLY0      = 3'd4,
    CFG_POLY1      = 3'd5,
    CFG_POLY2      = 3'd6,
    CFG_POLY3      = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_VECTOR = 1'b1
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_INIT,
    ST_EDGE,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [SHIFT_W-1:0]                       grid_shift;
    logic [DIM_W-1:0]                         grid_cols;
    logic [DIM_W-1:0]                         grid_rows;
    logic [THR_W-1:0]                         mag_thr;
    logic [NUM_POLY_REGS-1:0][POLY_CNT_W-1:0] poly_vtx;
  } cfg_t;

  typedef struct packed {
    logic load;        // vertex write this cycle
    logic capture;     // take in a vector
    logic setup;       // pixel position and squares
    logic poly_start;  // clear crossing parity
    logic rd_en;       // vertex table read
    logic rd_first;    // read is the closing vertex, no edge yet
    logic poly_done;   // fold parity into masked flag
    logic finish;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic busy;      // edge pipeline holds work
    logic parity;    // crossing parity of current polygon
    logic out_full;  // output register cannot take a result
  } sts_t;

endpackage

@@ src/mmvg_in_if.sv @@
interface mmvg_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [5:0]         vertex_slot;
  logic [12:0]        vertex_x;
  logic [12:0]        vertex_y;
  logic signed [15:0] mvx;
  logic signed [15:0] mvy;
  logic signed [1:0]  source_sign;
  logic signed [15:0] dest_x;
  logic signed [15:0] dest_y;

  modport source (
    output valid, action, vertex_slot, vertex_x, vertex_y,
    output mvx, mvy, source_sign, dest_x, dest_y,
    input  ready
  );
  modport sink (
    input  valid, action, vertex_slot, vertex_x, vertex_y,
    input  mvx, mvy, source_sign, dest_x, dest_y,
    output ready
  );
endinterface

@@ src/mmvg_out_if.sv @@
interface mmvg_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         cell_row;
  logic [9:0]         cell_col;
  logic signed [14:0] vec_dx;
  logic signed [14:0] vec_dy;
  logic               masked;
  logic               accepted;

  modport source (
    output valid, cell_row, cell_col, vec_dx, vec_dy, masked, accepted,
    input  ready
  );
  modport sink (
    input  valid, cell_row, cell_col, vec_dx, vec_dy, masked, accepted,
    output ready
  );
endinterface

@@ src/mmvg_cfg.sv @@
module mmvg_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mmvg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mmvg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output mmvg_pkg::cfg_t                   cfg_o
);
  import mmvg_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_SHIFT: cfg_d.grid_shift  = cfg_wdata_i[SHIFT_W-1:0];
        CFG_GRID_COLS:  cfg_d.grid_cols   = cfg_wdata_i[DIM_W-1:0];
        CFG_GRID_ROWS:  cfg_d.grid_rows   = cfg_wdata_i[DIM_W-1:0];
        CFG_MAG_THR:    cfg_d.mag_thr     = cfg_wdata_i[THR_W-1:0];
        CFG_POLY0:      cfg_d.poly_vtx[0] = cfg_wdata_i[POLY_CNT_W-1:0];
        CFG_POLY1:      cfg_d.poly_vtx[1] = cfg_wdata_i[POLY_CNT_W-1:0];
        CFG_POLY2:      cfg_d.poly_vtx[2] = cfg_wdata_i[POLY_CNT_W-1:0];
        CFG_POLY3:      cfg_d.poly_vtx[3] = cfg_wdata_i[POLY_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q            <= '0;
      cfg_q.grid_shift <= RST_GRID_SHIFT;
      cfg_q.grid_cols  <= RST_GRID_COLS;
      cfg_q.grid_rows  <= RST_GRID_ROWS;
      cfg_q.mag_thr    <= RST_MAG_THR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/mmvg_datapath.sv @@
module mmvg_datapath #(
  parameter int MAX_POLYGONS = 4,
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 13,
  localparam int Depth = MAX_POLYGONS * MAX_VERTICES,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmvg_pkg::cmd_t      cmd_i,
  input  mmvg_pkg::cfg_t      cfg_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  input  logic [5:0]          vertex_slot_i,
  input  logic [12:0]         vertex_x_i,
  input  logic [12:0]         vertex_y_i,
  input  logic signed [15:0]  mvx_i,
  input  logic signed [15:0]  mvy_i,
  input  logic signed [1:0]   source_sign_i,
  input  logic signed [15:0]  dest_x_i,
  input  logic signed [15:0]  dest_y_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [9:0]          cell_row_o,
  output logic [9:0]          cell_col_o,
  output logic signed [14:0]  vec_dx_o,
  output logic signed [14:0]  vec_dy_o,
  output logic                masked_o,
  output logic                accepted_o,
  output mmvg_pkg::sts_t      sts_o
);
  import mmvg_pkg::*;

  localparam int DW    = ((COORD_BITS + 1 > PX_W) ? COORD_BITS + 1 : PX_W) + 1;
  localparam int ProdW = 2 * DW;

  function automatic logic [CELL_W-1:0] last_cell(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] dm1;
    begin
      dm1 = dim - DIM_W'(1);
      if (dim == '0) return '0;
      if (dim > DIM_W'(DIM_MAX)) return CELL_W'(DIM_MAX - 1);
      return dm1[CELL_W-1:0];
    end
  endfunction

  function automatic logic [CELL_W-1:0] map_cell(input logic signed [15:0] d,
                                                 input logic [SHIFT_W-1:0] sh,
                                                 input logic [CELL_W-1:0] last);
    logic [14:0] c;
    begin
      c = d[14:0] >> sh;
      if (d[15]) return last;
      if (c > 15'(last)) return last;
      return c[CELL_W-1:0];
    end
  endfunction

  function automatic logic signed [VEC_W-1:0] scale(input logic signed [15:0] m,
                                                    input logic signed [1:0] s);
    logic signed [15:0]      q;
    logic signed [VEC_W-1:0] v;
    begin
      q = m >>> 2;
      v = VEC_W'(q);
      if (s[1]) return -v;
      if (s[0]) return v;
      return '0;
    end
  endfunction

  // vertex tables
  logic [COORD_BITS-1:0] mem_x_q [Depth];
  logic [COORD_BITS-1:0] mem_y_q [Depth];
  logic [COORD_BITS-1:0] vx_q, vy_q, prev_x_q, prev_y_q;
  logic                  slot_ok;
  logic [AddrW-1:0]      wr_addr;

  assign slot_ok = int'(vertex_slot_i) < Depth;
  assign wr_addr = AddrW'(vertex_slot_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      mem_x_q[wr_addr] <= COORD_BITS'(vertex_x_i);
      mem_y_q[wr_addr] <= COORD_BITS'(vertex_y_i);
    end
    if (cmd_i.rd_en) begin
      vx_q <= mem_x_q[rd_addr_i];
      vy_q <= mem_y_q[rd_addr_i];
    end
  end

  // item registers
  logic [CELL_W-1:0]       row_q, col_q;
  logic signed [VEC_W-1:0] dx_q, dy_q;
  logic signed [PX_W-1:0]  px_q, py_q;
  logic [SQ_W-1:0]         sqx_q, sqy_q;
  logic [PX_W-2:0]         pxu, pyu;
  logic signed [2*VEC_W-1:0] sqx_full, sqy_full;

  assign pxu      = (PX_W-1)'(col_q) << cfg_i.grid_shift;
  assign pyu      = (PX_W-1)'(row_q) << cfg_i.grid_shift;
  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q <= map_cell(dest_y_i, cfg_i.grid_shift, last_cell(cfg_i.grid_rows));
      col_q <= map_cell(dest_x_i, cfg_i.grid_shift, last_cell(cfg_i.grid_cols));
      dx_q  <= scale(mvx_i, source_sign_i);
      dy_q  <= scale(mvy_i, source_sign_i);
    end
    if (cmd_i.setup) begin
      px_q  <= signed'({1'b0, pxu});
      py_q  <= signed'({1'b0, pyu});
      sqx_q <= sqx_full[SQ_W-1:0];
      sqy_q <= sqy_full[SQ_W-1:0];
    end
  end

  // edge pipeline: read, cross products, compare
  logic                    rdv_q, rdf_q, bv_q, str_q, dpos_q, parity_q, masked_q;
  logic signed [ProdW-1:0] lhs_q, rhs_q, lhs_d, rhs_d;
  logic signed [DW-1:0]    xi, yi, xj, yj, pxs, pys, dy_e, dpx, dxe, dpy;
  logic                    straddle, left;

  always_comb begin
    xi       = signed'(DW'(vx_q));
    yi       = signed'(DW'(vy_q));
    xj       = signed'(DW'(prev_x_q));
    yj       = signed'(DW'(prev_y_q));
    pxs      = DW'(px_q);
    pys      = DW'(py_q);
    dy_e     = yj - yi;
    dpx      = pxs - xi;
    dxe      = xj - xi;
    dpy      = pys - yi;
    lhs_d    = dpx * dy_e;
    rhs_d    = dxe * dpy;
    straddle = ((yi <= pys) && (pys < yj)) || ((yj <= pys) && (pys < yi));
    left     = dpos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdv_q) begin
      prev_x_q <= vx_q;
      prev_y_q <= vy_q;
      str_q    <= straddle;
      dpos_q   <= !dy_e[DW-1] && (dy_e != '0);
      lhs_q    <= lhs_d;
      rhs_q    <= rhs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q    <= 1'b0;
      rdf_q    <= 1'b0;
      bv_q     <= 1'b0;
      parity_q <= 1'b0;
      masked_q <= 1'b0;
    end else begin
      rdv_q <= cmd_i.rd_en;
      rdf_q <= cmd_i.rd_first;
      bv_q  <= rdv_q && !rdf_q;
      if (cmd_i.poly_start) begin
        parity_q <= 1'b0;
      end else if (bv_q && str_q && left) begin
        parity_q <= !parity_q;
      end
      if (cmd_i.setup) begin
        masked_q <= 1'b0;
      end else if (cmd_i.poly_done) begin
        masked_q <= masked_q | parity_q;
      end
    end
  end

  // output register
  logic            out_valid_q;
  logic [THR_W-1:0] mag;

  assign mag = THR_W'(sqx_q) + THR_W'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      cell_row_o <= row_q;
      cell_col_o <= col_q;
      vec_dx_o   <= dx_q;
      vec_dy_o   <= dy_q;
      masked_o   <= masked_q;
      accepted_o <= !masked_q && (mag > cfg_i.mag_thr);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.busy      = rdv_q | bv_q;
  assign sts_o.parity    = parity_q;
  assign sts_o.out_full  = out_valid_q & !out_ready_i;

endmodule

@@ src/mmvg_ctrl.sv @@
`include "masked_motion_vector_gridder_assert.svh"

module mmvg_ctrl #(
  parameter int MAX_POLYGONS = 4,
  parameter int MAX_VERTICES = 16,
  localparam int Depth = MAX_POLYGONS * MAX_VERTICES,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mmvg_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  input  logic               in_action_i,
  output logic               in_ready_o,
  input  mmvg_pkg::sts_t     sts_i,
  output mmvg_pkg::cmd_t     cmd_o,
  output logic [AddrW-1:0]   rd_addr_o
);
  import mmvg_pkg::*;

  localparam int PolyW = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
  localparam int CntW  = $clog2(MAX_VERTICES + 1);

  ctrl_state_e            state_q, state_d;
  logic [PolyW-1:0]       poly_q, poly_d;
  logic [AddrW-1:0]       base_q, base_d;
  logic [CntW-1:0]        vtx_q, vtx_d, n_q, n_d, cnt;
  logic [POLY_CNT_W-1:0]  raw;
  logic                   last_poly;

  always_comb begin
    raw = '0;
    for (int k = 0; k < NUM_POLY_REGS; k++) begin
      if (int'(poly_q) == k) raw = cfg_i.poly_vtx[k];
    end
    cnt = (int'(raw) > MAX_VERTICES) ? CntW'(MAX_VERTICES) : CntW'(raw);
  end

  assign last_poly = int'(poly_q) == MAX_POLYGONS - 1;

  always_comb begin
    state_d    = state_q;
    poly_d     = poly_q;
    base_d     = base_q;
    vtx_d      = vtx_q;
    n_d        = n_q;
    cmd_o      = '0;
    rd_addr_o  = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ACT_VECTOR) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_SETUP;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        poly_d      = '0;
        base_d      = '0;
        state_d     = ST_INIT;
      end
      ST_INIT: begin
        if (cnt == '0) begin
          if (last_poly) begin
            state_d = ST_FINISH;
          end else begin
            poly_d = poly_q + PolyW'(1);
            base_d = AddrW'(int'(base_q) + MAX_VERTICES);
          end
        end else begin
          cmd_o.poly_start = 1'b1;
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_first   = 1'b1;
          rd_addr_o        = AddrW'(int'(base_q) + int'(cnt) - 1);
          vtx_d            = '0;
          n_d              = cnt;
          state_d          = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = AddrW'(int'(base_q) + int'(vtx_q));
        vtx_d       = vtx_q + CntW'(1);
        if (vtx_q == n_q - CntW'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          cmd_o.poly_done = 1'b1;
          if (sts_i.parity || last_poly) begin
            state_d = ST_FINISH;
          end else begin
            poly_d  = poly_q + PolyW'(1);
            base_d  = AddrW'(int'(base_q) + MAX_VERTICES);
            state_d = ST_INIT;
          end
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      poly_q  <= '0;
      base_q  <= '0;
      vtx_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      poly_q  <= poly_d;
      base_q  <= base_d;
      vtx_q   <= vtx_d;
      n_q     <= n_d;
    end
  end

  `MMVG_ASSERT_NXT(a_vec_to_setup, in_valid_i && in_ready_o && (in_action_i == ACT_VECTOR), state_q == ST_SETUP, "vector transfer did not start setup")
  `MMVG_ASSERT_IMP(a_drain_empty, (state_q == ST_DRAIN) && (state_d != ST_DRAIN), !sts_i.busy, "polygon closed with edges in flight")
  `MMVG_ASSERT_IMP(a_rd_range, cmd_o.rd_en, int'(rd_addr_o) < Depth, "vertex read beyond table")
  `MMVG_ASSERT_IMP(a_edge_count, state_q == ST_EDGE, (vtx_q < n_q) && (n_q != '0), "edge index past vertex count")

endmodule

@@ src/masked_motion_vector_gridder.sv @@
// Masked motion-vector gridder. Each input transfer either loads one mask
// vertex (action 0) or processes one motion vector (action 1). A load
// gives no result. A vector gives one result: grid cell, scaled vector,
// masked flag and accepted flag. A vector is captured, then set up, then
// tested against each polygon in turn; a polygon with no vertices is
// skipped, and testing stops at the first polygon holding the cell. The
// result then waits until the output register can take it. The single
// vertex-table read port walks one vertex per cycle through a three-stage
// edge pipeline. A finished result sits in the output register, so the
// next item is taken while it waits. Vertex tables are undefined until
// loaded.
module masked_motion_vector_gridder #(
  parameter int MAX_POLYGONS = 4,
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmvg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mmvg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  mmvg_in_if.sink                         in_i,
  mmvg_out_if.source                      out_o
);
  import mmvg_pkg::*;

  localparam int Depth = MAX_POLYGONS * MAX_VERTICES;
  localparam int AddrW = $clog2(Depth);

  cfg_t             cfg;
  cmd_t             cmd;
  sts_t             sts;
  logic [AddrW-1:0] rd_addr;

  mmvg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mmvg_ctrl #(
    .MAX_POLYGONS (MAX_POLYGONS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  mmvg_datapath #(
    .MAX_POLYGONS (MAX_POLYGONS),
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .rd_addr_i     (rd_addr),
    .vertex_slot_i (in_i.vertex_slot),
    .vertex_x_i    (in_i.vertex_x),
    .vertex_y_i    (in_i.vertex_y),
    .mvx_i         (in_i.mvx),
    .mvy_i         (in_i.mvy),
    .source_sign_i (in_i.source_sign),
    .dest_x_i      (in_i.dest_x),
    .dest_y_i      (in_i.dest_y),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .cell_row_o    (out_o.cell_row),
    .cell_col_o    (out_o.cell_col),
    .vec_dx_o      (out_o.vec_dx),
    .vec_dy_o      (out_o.vec_dy),
    .masked_o      (out_o.masked),
    .accepted_o    (out_o.accepted),
    .sts_o         (sts)
  );

endmodule
